// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mas_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FILT_W      = 24;
	localparam int MAG_W       = 48;
	localparam int THR_W       = 40;
	localparam int TIME_W      = 32;
	localparam int PERIOD_W    = 24;
	localparam int COUNT_W     = 8;
	localparam int QUAL_W      = 7;
	localparam int ALPHA_W     = 16;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 64;
	localparam int REG_IDX_W   = 2;

	// Register map, one register every eight bytes.
	localparam logic [REG_IDX_W-1:0] REG_ALPHA  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_THRESH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_AWAKE  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_REPORT = 2'd3;

	localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 16'd29491;
	localparam logic [THR_W-1:0]    THRESH_RST = 40'd697894;
	localparam logic [PERIOD_W-1:0] AWAKE_RST  = 24'd15000;
	localparam logic [PERIOD_W-1:0] REPORT_RST = 24'd60000;

	localparam logic [ALPHA_W:0] ALPHA_ONE = 17'd32768;

	// Multiplier operand selection.
	localparam logic [2:0] MUL_FX = 3'd0;
	localparam logic [2:0] MUL_FY = 3'd1;
	localparam logic [2:0] MUL_FZ = 3'd2;
	localparam logic [2:0] MUL_QX = 3'd3;
	localparam logic [2:0] MUL_QY = 3'd4;
	localparam logic [2:0] MUL_QZ = 3'd5;

	// Filter state write-back.
	localparam logic [1:0] FW_NONE = 2'd0;
	localparam logic [1:0] FW_X    = 2'd1;
	localparam logic [1:0] FW_Y    = 2'd2;
	localparam logic [1:0] FW_Z    = 2'd3;

	// Magnitude accumulator operation.
	localparam logic [1:0] MAG_HOLD = 2'd0;
	localparam logic [1:0] MAG_LOAD = 2'd1;
	localparam logic [1:0] MAG_ADD  = 2'd2;

	localparam logic [QUAL_W-1:0] QUAL_ZERO_EV  = 7'd100;
	localparam logic [QUAL_W-1:0] QUAL_ONE_EV   = 7'd75;
	localparam logic [QUAL_W-1:0] QUAL_TWO_EV   = 7'd50;
	localparam logic [QUAL_W-1:0] QUAL_THREE_EV = 7'd25;
	localparam logic [QUAL_W-1:0] QUAL_RESTLESS = 7'd0;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] accel_x;
		logic signed [SAMPLE_BITS-1:0] accel_y;
		logic signed [SAMPLE_BITS-1:0] accel_z;
		logic [TIME_W-1:0]             now_ms;
	} mas_in_t;

	typedef struct packed {
		logic               moving;
		logic               awake_event;
		logic               report_valid;
		logic [COUNT_W-1:0] awake_count;
		logic [QUAL_W-1:0]  sleep_quality;
	} mas_out_t;

	typedef struct packed {
		logic [ALPHA_W-1:0]  alpha_q15;
		logic [THR_W-1:0]    threshold_sq;
		logic [PERIOD_W-1:0] awake_period_ms;
		logic [PERIOD_W-1:0] report_period_ms;
	} mas_cfg_t;

	typedef struct packed {
		logic       load;
		logic [2:0] mul_sel;
		logic [1:0] filt_wr;
		logic [1:0] mag_op;
		logic       commit;
	} mas_cmd_t;

	function automatic logic [QUAL_W-1:0] quality(input logic [COUNT_W-1:0] cnt);
		logic [QUAL_W-1:0] q;
		case (cnt)
			8'd0:    q = QUAL_ZERO_EV;
			8'd1:    q = QUAL_ONE_EV;
			8'd2:    q = QUAL_TWO_EV;
			8'd3:    q = QUAL_THREE_EV;
			default: q = QUAL_RESTLESS;
		endcase
		return q;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/mas_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mas_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mas_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [mas_pkg::DATA_W-1:0]   pwdata,
	output logic      [mas_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	output mas_pkg::mas_cfg_t                 cfg
);

	mas_pkg::mas_cfg_t                   cfg_q;
	logic [mas_pkg::REG_IDX_W-1:0]       idx;
	logic                                wr_en;

	// Byte offset bits below the register stride are ignored.
	assign idx    = paddr[mas_pkg::ADDR_W-1:3];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_q15        <= mas_pkg::ALPHA_RST;
			cfg_q.threshold_sq     <= mas_pkg::THRESH_RST;
			cfg_q.awake_period_ms  <= mas_pkg::AWAKE_RST;
			cfg_q.report_period_ms <= mas_pkg::REPORT_RST;
		end else if (wr_en) begin
			unique case (idx)
				mas_pkg::REG_ALPHA:  cfg_q.alpha_q15 <= pwdata[mas_pkg::ALPHA_W-1:0];
				mas_pkg::REG_THRESH: cfg_q.threshold_sq <= pwdata[mas_pkg::THR_W-1:0];
				mas_pkg::REG_AWAKE:  cfg_q.awake_period_ms <= pwdata[mas_pkg::PERIOD_W-1:0];
				mas_pkg::REG_REPORT: cfg_q.report_period_ms <= pwdata[mas_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			mas_pkg::REG_ALPHA:  prdata = mas_pkg::DATA_W'(cfg_q.alpha_q15);
			mas_pkg::REG_THRESH: prdata = mas_pkg::DATA_W'(cfg_q.threshold_sq);
			mas_pkg::REG_AWAKE:  prdata = mas_pkg::DATA_W'(cfg_q.awake_period_ms);
			mas_pkg::REG_REPORT: prdata = mas_pkg::DATA_W'(cfg_q.report_period_ms);
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/mas_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mas_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        sample_valid,
	output logic             sample_stall,
	output logic             result_valid,
	input  wire logic        result_stall,
	output mas_pkg::mas_cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FX   = 4'd1;
	localparam logic [3:0] S_FY   = 4'd2;
	localparam logic [3:0] S_FZ   = 4'd3;
	localparam logic [3:0] S_QX   = 4'd4;
	localparam logic [3:0] S_QY   = 4'd5;
	localparam logic [3:0] S_QZ   = 4'd6;
	localparam logic [3:0] S_ACC  = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign sample_stall = (state_q != S_IDLE);
	assign result_valid = out_valid_q;
	assign out_free     = !out_valid_q || !result_stall;

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = mas_pkg::MUL_FX;
		cmd.filt_wr = mas_pkg::FW_NONE;
		cmd.mag_op  = mas_pkg::MAG_HOLD;
		state_nxt   = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = sample_valid;
				if (sample_valid) begin
					state_nxt = S_FX;
				end
			end
			S_FX: begin
				cmd.mul_sel = mas_pkg::MUL_FX;
				state_nxt   = S_FY;
			end
			S_FY: begin
				cmd.filt_wr = mas_pkg::FW_X;
				cmd.mul_sel = mas_pkg::MUL_FY;
				state_nxt   = S_FZ;
			end
			S_FZ: begin
				cmd.filt_wr = mas_pkg::FW_Y;
				cmd.mul_sel = mas_pkg::MUL_FZ;
				state_nxt   = S_QX;
			end
			S_QX: begin
				cmd.filt_wr = mas_pkg::FW_Z;
				cmd.mul_sel = mas_pkg::MUL_QX;
				state_nxt   = S_QY;
			end
			S_QY: begin
				cmd.mag_op  = mas_pkg::MAG_LOAD;
				cmd.mul_sel = mas_pkg::MUL_QY;
				state_nxt   = S_QZ;
			end
			S_QZ: begin
				cmd.mag_op  = mas_pkg::MAG_ADD;
				cmd.mul_sel = mas_pkg::MUL_QZ;
				state_nxt   = S_ACC;
			end
			S_ACC: begin
				cmd.mag_op = mas_pkg::MAG_ADD;
				state_nxt  = S_FIN;
			end
			S_FIN: begin
				// Hold the finished request until the result register frees up.
				cmd.commit = out_free;
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mas_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mas_dp #(
	parameter int FILT_FRAC_BITS = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mas_pkg::mas_cmd_t cmd,
	input  wire mas_pkg::mas_cfg_t cfg,
	input  wire mas_pkg::mas_in_t  sample,
	output mas_pkg::mas_out_t      result
);

	localparam int FILT_W = mas_pkg::FILT_W;
	localparam int D_W    = mas_pkg::SAMPLE_BITS + 1;
	localparam int SH_W   = D_W + FILT_FRAC_BITS;
	localparam int S_W    = ((SH_W > FILT_W) ? SH_W : FILT_W) + 1;
	localparam int MUL_W  = (S_W > mas_pkg::ALPHA_W + 2) ? S_W : mas_pkg::ALPHA_W + 2;
	localparam int P_W    = 2 * MUL_W;
	localparam int THR_SW = mas_pkg::THR_W + 2 * FILT_FRAC_BITS;
	localparam int CMP_W  = (mas_pkg::MAG_W > THR_SW) ? mas_pkg::MAG_W : THR_SW;
	localparam int TIME_W = mas_pkg::TIME_W;
	localparam int CNT_W  = mas_pkg::COUNT_W;

	mas_pkg::mas_in_t              smp_q;
	logic signed [FILT_W-1:0]      filt_q [3];
	logic signed [mas_pkg::SAMPLE_BITS-1:0] last_q [3];
	logic signed [mas_pkg::SAMPLE_BITS-1:0] raw [3];
	logic signed [S_W-1:0]         s_ax [3];
	logic signed [S_W-1:0]         d_ax;
	logic [mas_pkg::ALPHA_W:0]     alpha_c;
	logic signed [MUL_W-1:0]       mul_a;
	logic signed [MUL_W-1:0]       mul_b;
	logic signed [P_W-1:0]         prod_q;
	logic signed [P_W-1:0]         rnd;
	logic signed [P_W-1:0]         shifted;
	logic [P_W-FILT_W:0]           hi;
	logic signed [FILT_W-1:0]      filt_new;
	logic [mas_pkg::MAG_W-1:0]     mag_q;
	logic [mas_pkg::MAG_W-1:0]     sq;
	logic [CMP_W-1:0]              thr_ext;
	logic                          moving;
	logic                          awake_flag_q;
	logic [TIME_W-1:0]             awake_start_q;
	logic [TIME_W-1:0]             window_start_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [TIME_W-1:0]             start_sel;
	logic [TIME_W-1:0]             awake_el;
	logic [TIME_W-1:0]             win_el;
	logic                          event_hit;
	logic                          report;
	logic [CNT_W-1:0]              cnt_inc;
	mas_pkg::mas_out_t             res_q;

	assign raw[0] = smp_q.accel_x;
	assign raw[1] = smp_q.accel_y;
	assign raw[2] = smp_q.accel_z;

	assign alpha_c = (mas_pkg::ALPHA_W + 1)'(cfg.alpha_q15) > mas_pkg::ALPHA_ONE ?
		mas_pkg::ALPHA_ONE : (mas_pkg::ALPHA_W + 1)'(cfg.alpha_q15);

	// Filter input: previous output plus the raw step scaled into the filter format.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_ax    = S_W'(raw[i]) - S_W'(last_q[i]);
			s_ax[i] = S_W'(filt_q[i]) + (d_ax <<< FILT_FRAC_BITS);
		end
	end

	always_comb begin
		case (cmd.mul_sel)
			mas_pkg::MUL_FX: begin
				mul_a = MUL_W'(s_ax[0]);
				mul_b = MUL_W'($signed({1'b0, alpha_c}));
			end
			mas_pkg::MUL_FY: begin
				mul_a = MUL_W'(s_ax[1]);
				mul_b = MUL_W'($signed({1'b0, alpha_c}));
			end
			mas_pkg::MUL_FZ: begin
				mul_a = MUL_W'(s_ax[2]);
				mul_b = MUL_W'($signed({1'b0, alpha_c}));
			end
			mas_pkg::MUL_QX: begin
				mul_a = MUL_W'(filt_q[0]);
				mul_b = MUL_W'(filt_q[0]);
			end
			mas_pkg::MUL_QY: begin
				mul_a = MUL_W'(filt_q[1]);
				mul_b = MUL_W'(filt_q[1]);
			end
			mas_pkg::MUL_QZ: begin
				mul_a = MUL_W'(filt_q[2]);
				mul_b = MUL_W'(filt_q[2]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Round half up, then saturate to the filter width.
	always_comb begin
		rnd     = prod_q + P_W'(1 << 14);
		shifted = rnd >>> 15;
		hi      = shifted[P_W-1:FILT_W-1];
		if ((&hi) || !(|hi)) begin
			filt_new = shifted[FILT_W-1:0];
		end else if (shifted[P_W-1]) begin
			filt_new = {1'b1, {(FILT_W-1){1'b0}}};
		end else begin
			filt_new = {1'b0, {(FILT_W-1){1'b1}}};
		end
	end

	assign sq      = prod_q[mas_pkg::MAG_W-1:0];
	assign thr_ext = CMP_W'(cfg.threshold_sq) << (2 * FILT_FRAC_BITS);
	assign moving  = CMP_W'(mag_q) > thr_ext;

	always_comb begin
		start_sel = (moving && !awake_flag_q) ? smp_q.now_ms : awake_start_q;
		awake_el  = smp_q.now_ms - start_sel;
		event_hit = moving && (awake_el >= TIME_W'(cfg.awake_period_ms));
		cnt_inc   = (event_hit && !(&cnt_q)) ? cnt_q + CNT_W'(1) : cnt_q;
		win_el    = smp_q.now_ms - window_start_q;
		report    = win_el >= TIME_W'(cfg.report_period_ms);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			smp_q <= sample;
		end
		prod_q <= mul_a * mul_b;
		case (cmd.mag_op)
			mas_pkg::MAG_LOAD: mag_q <= sq;
			mas_pkg::MAG_ADD:  mag_q <= mag_q + sq;
			default: ;
		endcase
		if (cmd.commit) begin
			res_q.moving        <= moving;
			res_q.awake_event   <= event_hit;
			res_q.report_valid  <= report;
			res_q.awake_count   <= report ? cnt_inc : '0;
			res_q.sleep_quality <= report ? mas_pkg::quality(cnt_inc) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				filt_q[i] <= '0;
				last_q[i] <= '0;
			end
			awake_flag_q   <= 1'b0;
			awake_start_q  <= '0;
			window_start_q <= '0;
			cnt_q          <= '0;
		end else begin
			case (cmd.filt_wr)
				mas_pkg::FW_X: begin
					filt_q[0] <= filt_new;
					last_q[0] <= raw[0];
				end
				mas_pkg::FW_Y: begin
					filt_q[1] <= filt_new;
					last_q[1] <= raw[1];
				end
				mas_pkg::FW_Z: begin
					filt_q[2] <= filt_new;
					last_q[2] <= raw[2];
				end
				default: ;
			endcase
			if (cmd.commit) begin
				// A counted event ends the movement run; the next one starts fresh.
				awake_flag_q  <= moving && !event_hit;
				awake_start_q <= start_sel;
				cnt_q         <= report ? '0 : cnt_inc;
				if (report) begin
					window_start_q <= smp_q.now_ms;
				end
			end
		end
	end

	assign result = res_q;

endmodule

`default_nettype wire

// ----- rtl/motion_activity_sleep_score_top.sv -----
// A sample passes states FX, FY, FZ, QX, QY, QZ, ACC and FIN, where its result is registered;
// FIN waits while the output register is held, and the input stays stalled until idle. The one
// shared multiplier runs three filter products and three squares per sample, then ACC adds the last square.
// A finished result waits in the output register while the next sample is taken.
// Reset (arst_n low, asynchronous) clears filters, timers, the event count and
// restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module motion_activity_sleep_score_top #(
	parameter int FILT_FRAC_BITS = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       sample_valid,
	output logic                            sample_stall,
	input  wire mas_pkg::mas_in_t           sample,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output mas_pkg::mas_out_t               result,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [mas_pkg::ADDR_W-1:0] paddr,
	input  wire logic [mas_pkg::DATA_W-1:0] pwdata,
	output logic      [mas_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);

	mas_pkg::mas_cfg_t cfg;
	mas_pkg::mas_cmd_t cmd;

	mas_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mas_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	mas_dp #(
		.FILT_FRAC_BITS (FILT_FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg),
		.sample (sample),
		.result (result)
	);

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, sample_valid && !sample_stall, sample_stall, "request accepted but input not stalled next cycle")
	`ASSERT_SAME(a_commit_when_free, clk, arst_n, cmd.commit, !result_valid || !result_stall, "result register overwritten while stalled")
	`ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, result_valid, "committed result not presented")
	`ASSERT_SAME(a_quiet_between_reports, clk, arst_n, result_valid && !result.report_valid, result.awake_count == '0 && result.sleep_quality == '0, "score fields set without a report")

endmodule

`default_nettype wire

// ----- tb/motion_activity_sleep_score_top_tb.sv -----
`timescale 1ns / 1ps

module motion_activity_sleep_score_top_tb;
	import mas_pkg::*;

	localparam int FRAC_BITS    = 4;
	localparam int GAP_MAX      = 12;
	localparam int HOLD_CYCLES  = 250;
	localparam int QUIET_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 12;
	localparam int N_PHASES     = 8;
	localparam int SAT_PHASE    = 3;
	localparam int PHASE_ITEMS  = 55;
	localparam int SAT_ITEMS    = 262;
	localparam longint FILT_HI  = 64'sd8388607;
	localparam longint FILT_LO  = -64'sd8388608;

	typedef enum logic {ROW_SAMPLE, ROW_REG_WRITE} row_kind_e;

	typedef struct packed {
		row_kind_e            kind;
		logic [REG_IDX_W-1:0] reg_idx;
		logic [DATA_W-1:0]    reg_val;
		mas_in_t              smp;
		bit                   typed;
		mas_out_t             res;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                sample_valid;
	logic                sample_stall;
	mas_in_t             sample;
	logic                result_valid;
	logic                result_stall;
	mas_out_t            result;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// Register copies and filter/timer state of the scoring model.
	logic [ALPHA_W-1:0]            m_alpha;
	logic [THR_W-1:0]              m_thresh;
	logic [PERIOD_W-1:0]           m_awake_per;
	logic [PERIOD_W-1:0]           m_report_per;
	logic signed [FILT_W-1:0]      filt_st [3];
	logic signed [SAMPLE_BITS-1:0] last_st [3];
	bit                            awake_on;
	logic [TIME_W-1:0]             awake_t0;
	logic [TIME_W-1:0]             window_t0;
	logic [COUNT_W-1:0]            event_cnt;

	mas_out_t  pending_scores [$];
	stim_row_t directed_rows [$];
	mas_out_t  want_score;

	int  tx_gap_max = GAP_MAX;
	int  rx_gap_max = GAP_MAX;
	bit  hold_req = 1'b0;
	int  mismatches = 0;
	int  n_sent = 0;
	int  n_scored = 0;
	int  n_moving = 0;
	int  n_events = 0;
	int  n_reports = 0;
	int  n_writes = 0;

	motion_activity_sleep_score_top #(
		.FILT_FRAC_BITS(FRAC_BITS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// One axis of the high-pass filter: y = alpha * (y + ((x - xprev) << frac)),
	// rounded half up and clamped to the filter width.
	function automatic longint highpass(input int ax, input logic signed [SAMPLE_BITS-1:0] xs);
		longint a;
		longint s;
		longint y;
		a = (m_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(m_alpha);
		s = longint'(filt_st[ax]) + ((longint'(xs) - longint'(last_st[ax])) <<< FRAC_BITS);
		y = (s * a + (longint'(1) <<< 14)) >>> 15;
		if (y > FILT_HI)
			y = FILT_HI;
		else if (y < FILT_LO)
			y = FILT_LO;
		filt_st[ax] = y[FILT_W-1:0];
		last_st[ax] = xs;
		return y;
	endfunction

	function automatic mas_out_t score_sample(input mas_in_t s);
		mas_out_t          r;
		longint            fx;
		longint            fy;
		longint            fz;
		longint            mag;
		longint            thr;
		logic [TIME_W-1:0] held;
		r = '0;
		fx = highpass(0, s.accel_x);
		fy = highpass(1, s.accel_y);
		fz = highpass(2, s.accel_z);
		mag = fx * fx + fy * fy + fz * fz;
		thr = longint'(m_thresh) <<< (2 * FRAC_BITS);
		r.moving = (mag > thr);
		if (r.moving) begin
			if (!awake_on) begin
				awake_on = 1'b1;
				awake_t0 = s.now_ms;
			end
		end else begin
			awake_on = 1'b0;
		end
		held = s.now_ms - awake_t0;
		if (awake_on && held >= m_awake_per) begin
			if (event_cnt != '1)
				event_cnt = event_cnt + 1'b1;
			awake_on = 1'b0;
			r.awake_event = 1'b1;
		end
		// The event of this sample is already in the count that gets reported.
		held = s.now_ms - window_t0;
		if (held >= m_report_per) begin
			r.report_valid = 1'b1;
			r.awake_count = event_cnt;
			case (event_cnt)
				8'd0:    r.sleep_quality = QUAL_ZERO_EV;
				8'd1:    r.sleep_quality = QUAL_ONE_EV;
				8'd2:    r.sleep_quality = QUAL_TWO_EV;
				8'd3:    r.sleep_quality = QUAL_THREE_EV;
				default: r.sleep_quality = QUAL_RESTLESS;
			endcase
			event_cnt = '0;
			window_t0 = s.now_ms;
		end
		return r;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] jiggle(input logic [SAMPLE_BITS-1:0] v,
			input int span);
		return v + SAMPLE_BITS'($urandom_range(0, 2 * span)) - SAMPLE_BITS'(span);
	endfunction

	function automatic void add_sample(input logic [SAMPLE_BITS-1:0] x, y, z,
			input logic [TIME_W-1:0] t, input bit typed = 1'b0, input mas_out_t res = '0);
		stim_row_t r;
		r = '0;
		r.kind = ROW_SAMPLE;
		r.smp = {x, y, z, t};
		r.typed = typed;
		r.res = res;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_write(input logic [REG_IDX_W-1:0] idx,
			input logic [DATA_W-1:0] v);
		stim_row_t r;
		r = '0;
		r.kind = ROW_REG_WRITE;
		r.reg_idx = idx;
		r.reg_val = v;
		directed_rows.push_back(r);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endfunction

	task automatic apb_xfer(input bit wr, input logic [REG_IDX_W-1:0] idx,
			input logic [DATA_W-1:0] wd, output logic [DATA_W-1:0] rd);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 3'b000};
		pwdata <= wd;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] want;
		logic [DATA_W-1:0] got;
		want = '0;
		case (idx)
			REG_ALPHA: begin
				m_alpha = v[ALPHA_W-1:0];
				want = DATA_W'(m_alpha);
			end
			REG_THRESH: begin
				m_thresh = v[THR_W-1:0];
				want = DATA_W'(m_thresh);
			end
			REG_AWAKE: begin
				m_awake_per = v[PERIOD_W-1:0];
				want = DATA_W'(m_awake_per);
			end
			REG_REPORT: begin
				m_report_per = v[PERIOD_W-1:0];
				want = DATA_W'(m_report_per);
			end
			default: ;
		endcase
		apb_xfer(1'b1, idx, v, got);
		apb_xfer(1'b0, idx, '0, got);
		n_writes++;
		if (got !== want) begin
			$error("register %0d readback: expected %h, got %h", idx, want, got);
			mismatches++;
		end
	endtask

	task automatic send_sample(input mas_in_t s, input bit typed = 1'b0,
			input mas_out_t typed_res = '0);
		int       gap;
		mas_out_t want;
		gap = $urandom_range(0, tx_gap_max);
		if (gap != 0) begin
			@(negedge clk) sample_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample <= s;
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall);
		want = score_sample(s);
		if (typed)
			want = typed_res;
		pending_scores.push_back(want);
		n_sent++;
	endtask

	// Lets every pending score come out before registers are touched.
	task automatic drain();
		@(negedge clk) sample_valid <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_scores.size() == 0) begin
				$error("score with no request pending: %h", result);
				mismatches++;
			end else begin
				want_score = pending_scores.pop_front();
				n_scored++;
				check_field("moving", 8'(want_score.moving), 8'(result.moving));
				check_field("awake_event", 8'(want_score.awake_event),
					8'(result.awake_event));
				check_field("report_valid", 8'(want_score.report_valid),
					8'(result.report_valid));
				check_field("awake_count", want_score.awake_count, result.awake_count);
				check_field("sleep_quality", 8'(want_score.sleep_quality),
					8'(result.sleep_quality));
				n_moving += want_score.moving;
				n_events += want_score.awake_event;
				n_reports += want_score.report_valid;
			end
		end
	end

	// Result side: random stalls per request, plus one long hold-off on demand.
	initial begin
		int wait_n;
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				@(negedge clk) result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			wait_n = $urandom_range(0, rx_gap_max);
			if (wait_n != 0) begin
				@(negedge clk) result_stall <= 1'b1;
				repeat (wait_n - 1) @(negedge clk);
			end
			@(negedge clk) result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$error("no progress for %0d cycles", QUIET_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic [TIME_W-1:0] now;
		mas_in_t           cur;
		logic [DATA_W-1:0] v;
		int                step_max;
		int                motion_pct;
		sample_valid = 1'b0;
		sample = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		m_alpha = ALPHA_RST;
		m_thresh = THRESH_RST;
		m_awake_per = AWAKE_RST;
		m_report_per = REPORT_RST;
		for (int i = 0; i < 3; i++) begin
			filt_st[i] = '0;
			last_st[i] = '0;
		end
		awake_on = 1'b0;
		awake_t0 = '0;
		window_t0 = '0;
		event_cnt = '0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Reset defaults: a still sample at the time origin reports nothing.
		add_sample(16'sd0, 16'sd0, 16'sd0, 32'd0, 1'b1,
			mas_out_t'{1'b0, 1'b0, 1'b0, 8'd0, QUAL_RESTLESS});
		add_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd100);
		add_sample(-16'sd32768, -16'sd32768, -16'sd32768, 32'd200);
		add_sample(-16'sd32768, -16'sd32768, -16'sd32768, 32'd15200);
		add_sample(16'sd0, 16'sd0, 16'sd0, 32'd60000);
		add_sample(16'sd0, 16'sd0, 16'sd0, 32'd60030);
		// With a zero report period every sample reports.
		add_write(REG_REPORT, '0);
		add_sample(16'sd5, 16'sd5, 16'sd5, 32'd60100);
		// A zero alpha clears the filter, so nothing moves.
		add_write(REG_ALPHA, '0);
		add_sample(16'sd32767, -16'sd32768, 16'sd12345, 32'd60101, 1'b1,
			mas_out_t'{1'b0, 1'b0, 1'b1, 8'd0, QUAL_ZERO_EV});
		// Alpha of one, no threshold and no awake period: each moving sample
		// counts an event at once, and it shows in the report of the same sample.
		add_write(REG_ALPHA, DATA_W'(ALPHA_ONE));
		add_write(REG_THRESH, '0);
		add_write(REG_AWAKE, '0);
		add_sample(16'sd1, 16'sd0, 16'sd0, 32'd60102, 1'b1,
			mas_out_t'{1'b1, 1'b1, 1'b1, 8'd1, QUAL_ONE_EV});
		add_sample(16'sd1, 16'sd0, 16'sd0, 32'd60103, 1'b1,
			mas_out_t'{1'b1, 1'b1, 1'b1, 8'd1, QUAL_ONE_EV});
		add_write(REG_REPORT, 64'hFF_FFFF);
		add_sample(-16'sd32768, 16'sd32767, -16'sd1, 32'd60104);
		add_sample(-16'sd32768, 16'sd32767, -16'sd1, 32'd60105);
		// Alpha above one behaves as one.
		add_write(REG_ALPHA, 64'hFFFF);
		add_sample(16'sd32767, -16'sd32768, 16'sd0, 32'd60106);
		add_sample(16'sd0, 16'sd0, 16'sd0, 32'd60106);
		add_write(REG_THRESH, 64'hFF_FFFF_FFFF);
		add_write(REG_AWAKE, 64'hFF_FFFF);
		// Timestamps across the 32-bit wrap.
		add_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'hFFFF_FFF0);
		add_sample(-16'sd32768, -16'sd32768, -16'sd32768, 32'h0000_0010);
		add_sample(-16'sd32768, -16'sd32768, -16'sd32768, 32'h00FF_FFFF);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG_WRITE) begin
				drain();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			end else begin
				send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].res);
			end
		end

		now = 32'h00FF_FFFF;
		cur = '0;
		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			if (ph == SAT_PHASE) begin
				// Back-to-back events in one long window run the count into saturation.
				write_reg(REG_ALPHA, DATA_W'(ALPHA_ONE));
				write_reg(REG_THRESH, '0);
				write_reg(REG_AWAKE, '0);
				write_reg(REG_REPORT, 64'hFF_FFFF);
				tx_gap_max = 0;
				rx_gap_max = 0;
				now = now + 32'h00FF_FFFF;
				cur.now_ms = now;
				send_sample(cur);
				for (int i = 0; i < SAT_ITEMS; i++) begin
					now = now + 1;
					cur = {jiggle(cur.accel_x, 32768), jiggle(cur.accel_y, 32768),
						jiggle(cur.accel_z, 32768), now};
					send_sample(cur);
				end
				now = now + 32'h00FF_FFFF;
				cur.now_ms = now;
				send_sample(cur);
			end else begin
				case ($urandom_range(0, 6))
					0:       v = '0;
					1:       v = DATA_W'(ALPHA_ONE);
					2:       v = 64'hFFFF;
					3:       v = $urandom_range(32'h8001, 32'hFFFF);
					default: v = $urandom_range(24000, 32767);
				endcase
				write_reg(REG_ALPHA, v);
				case ($urandom_range(0, 5))
					0:       v = '0;
					1:       v = 64'hFF_FFFF_FFFF;
					2:       v = {$urandom, $urandom};
					default: v = $urandom_range(0, 3000000);
				endcase
				write_reg(REG_THRESH, v);
				case ($urandom_range(0, 4))
					0:       v = '0;
					1:       v = 64'hFF_FFFF;
					default: v = $urandom_range(0, 20000);
				endcase
				write_reg(REG_AWAKE, v);
				case ($urandom_range(0, 4))
					0:       v = '0;
					1:       v = 64'hFF_FFFF;
					default: v = $urandom_range(1000, 120000);
				endcase
				write_reg(REG_REPORT, v);
				tx_gap_max = $urandom_range(0, 1) ? GAP_MAX : 0;
				rx_gap_max = $urandom_range(0, 1) ? GAP_MAX : 0;
				if (ph == 1) begin
					// Keep offering samples while the result side holds off.
					tx_gap_max = 0;
					hold_req = 1'b1;
				end
				case ($urandom_range(0, 3))
					0:       step_max = 2;
					1:       step_max = 200;
					2:       step_max = 2500;
					default: step_max = 20000;
				endcase
				motion_pct = $urandom_range(10, 90);
				if ($urandom_range(0, 3) == 0)
					now = $urandom;
				for (int i = 0; i < PHASE_ITEMS; i++) begin
					if ($urandom_range(0, 39) == 0)
						now = now + $urandom_range(0, 33554431);
					else
						now = now + $urandom_range(0, step_max);
					if ($urandom_range(0, 99) >= motion_pct)
						cur = {jiggle(cur.accel_x, 6), jiggle(cur.accel_y, 6),
							jiggle(cur.accel_z, 6), now};
					else if ($urandom_range(0, 1))
						cur = {jiggle(cur.accel_x, 32768), jiggle(cur.accel_y, 32768),
							jiggle(cur.accel_z, 32768), now};
					else
						cur = {jiggle(cur.accel_x, 4000), jiggle(cur.accel_y, 4000),
							jiggle(cur.accel_z, 4000), now};
					send_sample(cur);
				end
			end
		end

		drain();
		$display("Run covered %0d samples, %0d scores checked: %0d moving, %0d awake events,",
			n_sent, n_scored, n_moving, n_events);
		$display("%0d reports, across %0d register writes including extremes and count saturation.",
			n_reports, n_writes);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mas_pkg.sv
rtl/mas_regs.sv
rtl/mas_ctrl.sv
rtl/mas_dp.sv
rtl/motion_activity_sleep_score_top.sv
tb/motion_activity_sleep_score_top_tb.sv
